// ----- hw/rtl/asgr_pkg.sv -----
package asgr_pkg;

   localparam int MAX_CHANNEL_DIGITS = 3;

   localparam logic [23:0] DEFAULT_FG_RESET = 24'hd3d7cf;
   localparam logic [23:0] DEFAULT_BG_RESET = 24'h000000;

   localparam logic [7:0] CHAR_ESC     = 8'h1b;
   localparam logic [7:0] CHAR_NL      = 8'h0a;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5b;
   localparam logic [7:0] CHAR_SEMI    = 8'h3b;
   localparam logic [7:0] CHAR_M       = 8'h6d;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_2       = 8'h32;
   localparam logic [7:0] CHAR_3       = 8'h33;
   localparam logic [7:0] CHAR_4       = 8'h34;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] CHAR_7       = 8'h37;
   localparam logic [7:0] CHAR_8       = 8'h38;
   localparam logic [7:0] CHAR_9       = 8'h39;

   localparam logic [0:0] CSR_DEFAULT_FG = 1'b0;
   localparam logic [0:0] CSR_DEFAULT_BG = 1'b1;

   localparam logic [23:0] PALETTE [8] = '{
      24'h000000, 24'hcc0000, 24'h4e9a06, 24'hc4a000,
      24'h729fcf, 24'h75507b, 24'h06989a, 24'hd3d7cf
   };

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BRACKET,
      PH_CODE,
      PH_FG,
      PH_BG,
      PH_END
   } phase_type;

   typedef enum logic [2:0] {
      EX_NONE,
      EX_SEL,
      EX_R,
      EX_G,
      EX_B,
      EX_DONE,
      EX_SKIP
   } ext_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_GLYPH,
      ACT_NEWLINE,
      ACT_TAB
   } action_type;

   typedef struct packed {
      logic        bold_font;
      logic [23:0] bg_color;
      logic [23:0] fg_color;
      logic [7:0]  glyph;
      action_type  action;
   } result_type;

endpackage

// ----- hw/rtl/ansi_sgr_escape_parser.sv -----
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle while rsp_tready does not hold back a result; the parser state updates once per
// byte, as the byte moves from the input register to the result register.
// Reset (synchronous, active high) empties both registers, returns the parser to idle and
// loads the default colours with their reset values.
module ansi_sgr_escape_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [1:0] action, [9:2] glyph, [33:10] fg_color,
                                    // [57:34] bg_color, [58] bold_font
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   asgr_pkg::result_type out_data_ff;
   logic [23:0]          default_fg_ff;
   logic [23:0]          default_bg_ff;
   logic                 out_ready;
   logic                 step;
   asgr_pkg::result_type result;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_data_ff};

   asgr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .default_fg (default_fg_ff),
      .default_bg (default_bg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff <= asgr_pkg::DEFAULT_FG_RESET;
         default_bg_ff <= asgr_pkg::DEFAULT_BG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            asgr_pkg::CSR_DEFAULT_FG: default_fg_ff <= csr_wdata;
            asgr_pkg::CSR_DEFAULT_BG: default_bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ----- hw/rtl/asgr_parser.sv -----
module asgr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           byte_in,
   input  logic [23:0]          default_fg,
   input  logic [23:0]          default_bg,
   output asgr_pkg::result_type result
);

   asgr_pkg::phase_type phase_ff, phase_in;
   asgr_pkg::ext_type   ext_ff, ext_in;
   logic                target_bg_ff, target_bg_in;
   logic [1:0]          dcnt_ff, dcnt_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [7:0]          blue_ff, blue_in;
   logic                bold_ff, bold_in;
   logic                clear_pend_ff, clear_pend_in;
   logic [23:0]         fg_ff, fg_in;
   logic [23:0]         bg_ff, bg_in;

   logic                is_digit;
   logic                in_channel;
   logic [7:0]          acc_sel;
   logic [7:0]          acc_new;
   logic [1:0]          dcnt_sum;
   asgr_pkg::ext_type   ext_next_chan;
   asgr_pkg::action_type action;
   logic [7:0]          glyph;
   logic                finish;
   logic                abort;
   logic                idle_handle;

   assign is_digit   = byte_in inside {[asgr_pkg::CHAR_0:asgr_pkg::CHAR_9]};
   assign in_channel = (ext_ff == asgr_pkg::EX_R) || (ext_ff == asgr_pkg::EX_G) ||
                       (ext_ff == asgr_pkg::EX_B);
   assign dcnt_sum   = dcnt_ff + 2'd1;

   always_comb begin
      case (ext_ff)
         asgr_pkg::EX_R: begin
            acc_sel       = red_ff;
            ext_next_chan = asgr_pkg::EX_G;
         end
         asgr_pkg::EX_G: begin
            acc_sel       = green_ff;
            ext_next_chan = asgr_pkg::EX_B;
         end
         default: begin
            acc_sel       = blue_ff;
            ext_next_chan = asgr_pkg::EX_DONE;
         end
      endcase
   end

   assign acc_new = {acc_sel[4:0], 3'b000} + {acc_sel[6:0], 1'b0} +
                    (byte_in - asgr_pkg::CHAR_0);

   always_comb begin
      phase_in      = phase_ff;
      ext_in        = ext_ff;
      target_bg_in  = target_bg_ff;
      dcnt_in       = dcnt_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      bold_in       = bold_ff;
      clear_pend_in = clear_pend_ff;
      fg_in         = fg_ff;
      bg_in         = bg_ff;
      action        = asgr_pkg::ACT_NONE;
      glyph         = 8'h00;
      finish        = 1'b0;
      abort         = 1'b0;
      idle_handle   = 1'b0;

      case (phase_ff)
         asgr_pkg::PH_IDLE: begin
            idle_handle = 1'b1;
         end
         asgr_pkg::PH_BRACKET: begin
            if (byte_in == asgr_pkg::CHAR_LBRACK) begin
               phase_in = asgr_pkg::PH_CODE;
            end else begin
               abort       = 1'b1;
               idle_handle = 1'b1;
            end
         end
         asgr_pkg::PH_CODE: begin
            if (in_channel) begin
               if (is_digit) begin
                  case (ext_ff)
                     asgr_pkg::EX_R: red_in   = acc_new;
                     asgr_pkg::EX_G: green_in = acc_new;
                     default:        blue_in  = acc_new;
                  endcase
                  if (dcnt_sum >= 2'(asgr_pkg::MAX_CHANNEL_DIGITS)) begin
                     dcnt_in  = 2'd0;
                     ext_in   = ext_next_chan;
                     phase_in = asgr_pkg::PH_END;
                  end else begin
                     dcnt_in = dcnt_sum;
                  end
               end else if (byte_in == asgr_pkg::CHAR_SEMI) begin
                  dcnt_in = 2'd0;
                  ext_in  = ext_next_chan;
               end else if (byte_in == asgr_pkg::CHAR_M && ext_ff == asgr_pkg::EX_B) begin
                  ext_in = asgr_pkg::EX_DONE;
                  finish = 1'b1;
               end else begin
                  abort = 1'b1;
               end
            end else if (ext_ff == asgr_pkg::EX_SEL) begin
               if (byte_in == asgr_pkg::CHAR_2) begin
                  ext_in   = asgr_pkg::EX_R;
                  red_in   = 8'h00;
                  green_in = 8'h00;
                  blue_in  = 8'h00;
                  dcnt_in  = 2'd0;
                  phase_in = asgr_pkg::PH_END;
               end else if (byte_in == asgr_pkg::CHAR_5) begin
                  ext_in   = asgr_pkg::EX_SKIP;
                  phase_in = asgr_pkg::PH_END;
               end else begin
                  abort = 1'b1;
               end
            end else if (ext_ff == asgr_pkg::EX_SKIP) begin
               if (is_digit) begin
                  ext_in = asgr_pkg::EX_SKIP;
               end else if (byte_in == asgr_pkg::CHAR_SEMI) begin
                  ext_in = asgr_pkg::EX_NONE;
               end else if (byte_in == asgr_pkg::CHAR_M) begin
                  finish = 1'b1;
               end else begin
                  abort = 1'b1;
               end
            end else if (byte_in == asgr_pkg::CHAR_0) begin
               fg_in         = default_fg;
               bg_in         = default_bg;
               bold_in       = 1'b0;
               clear_pend_in = 1'b0;
               phase_in      = asgr_pkg::PH_END;
            end else if (byte_in == asgr_pkg::CHAR_2) begin
               if (clear_pend_ff) begin
                  bold_in = 1'b0;
               end else if (bold_ff) begin
                  clear_pend_in = 1'b1;
               end else begin
                  bold_in = 1'b1;
               end
               phase_in = asgr_pkg::PH_END;
            end else if (byte_in == asgr_pkg::CHAR_3) begin
               phase_in = asgr_pkg::PH_FG;
            end else if (byte_in == asgr_pkg::CHAR_4) begin
               phase_in = asgr_pkg::PH_BG;
            end else if (byte_in == asgr_pkg::CHAR_M) begin
               finish = 1'b1;
            end
         end
         asgr_pkg::PH_FG, asgr_pkg::PH_BG: begin
            if (byte_in inside {[asgr_pkg::CHAR_0:asgr_pkg::CHAR_7]}) begin
               if (phase_ff == asgr_pkg::PH_BG) begin
                  bg_in = asgr_pkg::PALETTE[byte_in[2:0]];
               end else begin
                  fg_in = asgr_pkg::PALETTE[byte_in[2:0]];
               end
               phase_in = asgr_pkg::PH_END;
            end else if (byte_in == asgr_pkg::CHAR_8) begin
               ext_in       = asgr_pkg::EX_SEL;
               target_bg_in = (phase_ff == asgr_pkg::PH_BG);
               phase_in     = asgr_pkg::PH_END;
            end else if (byte_in == asgr_pkg::CHAR_M) begin
               finish = 1'b1;
            end
         end
         asgr_pkg::PH_END: begin
            if (byte_in == asgr_pkg::CHAR_SEMI) begin
               phase_in = asgr_pkg::PH_CODE;
            end else if (byte_in == asgr_pkg::CHAR_M) begin
               finish = 1'b1;
            end
         end
         default: begin
            abort = 1'b1;
         end
      endcase

      if (finish && ext_in == asgr_pkg::EX_DONE) begin
         if (target_bg_ff) begin
            bg_in = {red_in, green_in, blue_in};
         end else begin
            fg_in = {red_in, green_in, blue_in};
         end
      end

      if (finish || abort) begin
         phase_in      = asgr_pkg::PH_IDLE;
         ext_in        = asgr_pkg::EX_NONE;
         dcnt_in       = 2'd0;
         clear_pend_in = 1'b0;
      end

      if (idle_handle) begin
         if (byte_in == asgr_pkg::CHAR_NL) begin
            action = asgr_pkg::ACT_NEWLINE;
         end else if (byte_in == asgr_pkg::CHAR_TAB) begin
            action = asgr_pkg::ACT_TAB;
         end else if (byte_in == asgr_pkg::CHAR_ESC) begin
            phase_in = asgr_pkg::PH_BRACKET;
         end else begin
            action = asgr_pkg::ACT_GLYPH;
            glyph  = byte_in;
         end
      end
   end

   always_comb begin
      result.action    = action;
      result.glyph     = glyph;
      result.fg_color  = fg_in;
      result.bg_color  = bg_in;
      result.bold_font = bold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= asgr_pkg::PH_IDLE;
         ext_ff        <= asgr_pkg::EX_NONE;
         target_bg_ff  <= 1'b0;
         dcnt_ff       <= 2'd0;
         red_ff        <= 8'h00;
         green_ff      <= 8'h00;
         blue_ff       <= 8'h00;
         bold_ff       <= 1'b0;
         clear_pend_ff <= 1'b0;
         fg_ff         <= asgr_pkg::DEFAULT_FG_RESET;
         bg_ff         <= asgr_pkg::DEFAULT_BG_RESET;
      end else if (step) begin
         phase_ff      <= phase_in;
         ext_ff        <= ext_in;
         target_bg_ff  <= target_bg_in;
         dcnt_ff       <= dcnt_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
         bold_ff       <= bold_in;
         clear_pend_ff <= clear_pend_in;
         fg_ff         <= fg_in;
         bg_ff         <= bg_in;
      end
   end

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STREAM_ITEMS   = 1950;
   localparam int CONFIG_EVERY   = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [23:0] csr_wdata;

   // console interpreter state as the block should hold it
   asgr_pkg::phase_type ph;
   asgr_pkg::ext_type   ex;
   logic        tgt_bg;
   logic [1:0]  digits;
   logic [7:0]  chan_r, chan_g, chan_b;
   logic        bold, bold_clear_armed;
   logic [23:0] fg_now, bg_now, dflt_fg, dflt_bg;

   asgr_pkg::result_type pending_results[$];
   logic [7:0]  chunk[$];
   int          mismatches;
   int          results_seen;
   int          sent_count;
   int          idle_cycles;
   bit          pace_on;

   ansi_sgr_escape_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void close_sequence();
      ph = asgr_pkg::PH_IDLE;
      ex = asgr_pkg::EX_NONE;
      digits = 2'd0;
      bold_clear_armed = 1'b0;
   endfunction

   function automatic void commit_sequence();
      if (ex == asgr_pkg::EX_DONE) begin
         if (tgt_bg) bg_now = {chan_r, chan_g, chan_b};
         else fg_now = {chan_r, chan_g, chan_b};
      end
      close_sequence();
   endfunction

   function automatic asgr_pkg::action_type plain_byte(logic [7:0] c);
      if (c == asgr_pkg::CHAR_NL) return asgr_pkg::ACT_NEWLINE;
      if (c == asgr_pkg::CHAR_TAB) return asgr_pkg::ACT_TAB;
      if (c == asgr_pkg::CHAR_ESC) begin
         ph = asgr_pkg::PH_BRACKET;
         return asgr_pkg::ACT_NONE;
      end
      return asgr_pkg::ACT_GLYPH;
   endfunction

   function automatic asgr_pkg::result_type interpret_byte(logic [7:0] c);
      asgr_pkg::result_type r;
      logic       is_digit;
      logic [7:0] acc;
      is_digit = (c >= asgr_pkg::CHAR_0) && (c <= asgr_pkg::CHAR_9);
      r = '0;
      r.action = asgr_pkg::ACT_NONE;
      case (ph)
         asgr_pkg::PH_IDLE: r.action = plain_byte(c);
         asgr_pkg::PH_BRACKET: begin
            if (c == asgr_pkg::CHAR_LBRACK) begin
               ph = asgr_pkg::PH_CODE;
            end else begin
               close_sequence();
               r.action = plain_byte(c);
            end
         end
         asgr_pkg::PH_CODE: begin
            if (ex == asgr_pkg::EX_R || ex == asgr_pkg::EX_G || ex == asgr_pkg::EX_B) begin
               if (is_digit) begin
                  acc = (ex == asgr_pkg::EX_R) ? chan_r :
                        (ex == asgr_pkg::EX_G) ? chan_g : chan_b;
                  acc = 8'(acc * 10 + (c - asgr_pkg::CHAR_0));
                  case (ex)
                     asgr_pkg::EX_R: chan_r = acc;
                     asgr_pkg::EX_G: chan_g = acc;
                     default: chan_b = acc;
                  endcase
                  digits = digits + 2'd1;
                  if (digits >= asgr_pkg::MAX_CHANNEL_DIGITS) begin
                     digits = 2'd0;
                     ex = asgr_pkg::ext_type'(ex + 1);
                     ph = asgr_pkg::PH_END;
                  end
               end else if (c == asgr_pkg::CHAR_SEMI) begin
                  digits = 2'd0;
                  ex = asgr_pkg::ext_type'(ex + 1);
               end else if (c == asgr_pkg::CHAR_M && ex == asgr_pkg::EX_B) begin
                  ex = asgr_pkg::EX_DONE;
                  commit_sequence();
               end else begin
                  close_sequence();
               end
            end else if (ex == asgr_pkg::EX_SEL) begin
               if (c == asgr_pkg::CHAR_2) begin
                  ex = asgr_pkg::EX_R;
                  chan_r = 8'd0;
                  chan_g = 8'd0;
                  chan_b = 8'd0;
                  digits = 2'd0;
                  ph = asgr_pkg::PH_END;
               end else if (c == asgr_pkg::CHAR_5) begin
                  ex = asgr_pkg::EX_SKIP;
                  ph = asgr_pkg::PH_END;
               end else begin
                  close_sequence();
               end
            end else if (ex == asgr_pkg::EX_SKIP) begin
               if (c == asgr_pkg::CHAR_SEMI) ex = asgr_pkg::EX_NONE;
               else if (c == asgr_pkg::CHAR_M) commit_sequence();
               else if (!is_digit) close_sequence();
            end else if (c == asgr_pkg::CHAR_0) begin
               fg_now = dflt_fg;
               bg_now = dflt_bg;
               bold = 1'b0;
               bold_clear_armed = 1'b0;
               ph = asgr_pkg::PH_END;
            end else if (c == asgr_pkg::CHAR_2) begin
               if (bold_clear_armed) bold = 1'b0;
               else if (bold) bold_clear_armed = 1'b1;
               else bold = 1'b1;
               ph = asgr_pkg::PH_END;
            end else if (c == asgr_pkg::CHAR_3) begin
               ph = asgr_pkg::PH_FG;
            end else if (c == asgr_pkg::CHAR_4) begin
               ph = asgr_pkg::PH_BG;
            end else if (c == asgr_pkg::CHAR_M) begin
               commit_sequence();
            end
         end
         asgr_pkg::PH_FG, asgr_pkg::PH_BG: begin
            if (c >= asgr_pkg::CHAR_0 && c <= asgr_pkg::CHAR_7) begin
               if (ph == asgr_pkg::PH_BG) bg_now = asgr_pkg::PALETTE[3'(c - asgr_pkg::CHAR_0)];
               else fg_now = asgr_pkg::PALETTE[3'(c - asgr_pkg::CHAR_0)];
               ph = asgr_pkg::PH_END;
            end else if (c == asgr_pkg::CHAR_8) begin
               ex = asgr_pkg::EX_SEL;
               tgt_bg = (ph == asgr_pkg::PH_BG);
               ph = asgr_pkg::PH_END;
            end else if (c == asgr_pkg::CHAR_M) begin
               commit_sequence();
            end
         end
         asgr_pkg::PH_END: begin
            if (c == asgr_pkg::CHAR_SEMI) ph = asgr_pkg::PH_CODE;
            else if (c == asgr_pkg::CHAR_M) commit_sequence();
         end
         default: close_sequence();
      endcase
      r.glyph = (r.action == asgr_pkg::ACT_GLYPH) ? c : 8'h00;
      r.fg_color = fg_now;
      r.bg_color = bg_now;
      r.bold_font = bold;
      return r;
   endfunction

   always @(posedge clock) begin
      asgr_pkg::result_type want, got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == asgr_pkg::CSR_DEFAULT_FG) dflt_fg = csr_wdata;
            else dflt_bg = csr_wdata;
         end
         if (req_tvalid && req_tready) pending_results.push_back(interpret_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = asgr_pkg::result_type'(rsp_tdata[58:0]);
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing expected: %h", results_seen,
                           rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (got.action !== want.action || got.glyph !== want.glyph ||
                   got.fg_color !== want.fg_color || got.bg_color !== want.bg_color ||
                   got.bold_font !== want.bold_font) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d expected/actual: action %0d/%0d glyph %h/%h ",
                               "fg %h/%h bg %h/%h bold %b/%b"}, results_seen,
                              want.action, got.action, want.glyph, got.glyph,
                              want.fg_color, got.fg_color, want.bg_color, got.bg_color,
                              want.bold_font, got.bold_font);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            if (pace_on && $urandom_range(0, 99) < 25) hold = pick_gap();
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      gap = (pace_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [23:0] value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] pick_colour();
      case ($urandom_range(0, 3))
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom_range(0, 24'hffffff));
      endcase
   endfunction

   function automatic void add_channel();
      repeat ($urandom_range(0, 3))
         chunk.push_back(asgr_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_code();
      logic [7:0] lead;
      lead = $urandom_range(0, 1) ? asgr_pkg::CHAR_4 : asgr_pkg::CHAR_3;
      case ($urandom_range(0, 9))
         0: chunk.push_back(asgr_pkg::CHAR_0);
         1, 2: chunk.push_back(asgr_pkg::CHAR_2);
         3, 4: begin
            chunk.push_back(lead);
            chunk.push_back(asgr_pkg::CHAR_0 + 8'($urandom_range(0, 7)));
         end
         5, 6: begin
            chunk.push_back(lead);
            chunk.push_back(asgr_pkg::CHAR_8);
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            chunk.push_back(asgr_pkg::CHAR_2);
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            add_channel();
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            add_channel();
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            add_channel();
         end
         7: begin
            chunk.push_back(lead);
            chunk.push_back(asgr_pkg::CHAR_8);
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            chunk.push_back(asgr_pkg::CHAR_5);
            chunk.push_back(asgr_pkg::CHAR_SEMI);
            add_channel();
         end
         8: chunk.push_back(lead);
         default: chunk.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   function automatic void build_sequence(input bit broken);
      int n;
      chunk.push_back(asgr_pkg::CHAR_ESC);
      chunk.push_back(asgr_pkg::CHAR_LBRACK);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         if (i > 0) chunk.push_back(asgr_pkg::CHAR_SEMI);
         add_code();
      end
      chunk.push_back(asgr_pkg::CHAR_M);
      if (broken) begin
         n = $urandom_range(1, chunk.size() - 1);
         if ($urandom_range(0, 1)) chunk[n] = 8'($urandom_range(0, 255));
         else while (chunk.size() > n) chunk.pop_back();
      end
   endfunction

   task automatic test_plain_bytes();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(asgr_pkg::CHAR_NL);
      send_byte(asgr_pkg::CHAR_TAB);
      send_byte(asgr_pkg::CHAR_ESC);
      send_text("A");
   endtask

   task automatic test_palette_and_bold();
      send_byte(asgr_pkg::CHAR_ESC);
      send_text("[47;2;2;2m");
   endtask

   task automatic test_truecolour();
      send_byte(asgr_pkg::CHAR_ESC);
      send_text("[38;2;999;;256m");
   endtask

   task automatic test_default_colours();
      write_csr(asgr_pkg::CSR_DEFAULT_FG, 24'h000000);
      write_csr(asgr_pkg::CSR_DEFAULT_BG, 24'hffffff);
      send_byte(asgr_pkg::CHAR_ESC);
      send_byte(asgr_pkg::CHAR_LBRACK);
      send_byte(asgr_pkg::CHAR_NL);
      send_text("0m");
   endtask

   task automatic test_random_stream();
      int next_config;
      int r;
      next_config = sent_count + CONFIG_EVERY;
      while (sent_count < STREAM_ITEMS) begin
         chunk.delete();
         r = $urandom_range(0, 99);
         if (r < 35) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 11))
                  0: chunk.push_back(asgr_pkg::CHAR_NL);
                  1: chunk.push_back(asgr_pkg::CHAR_TAB);
                  default: chunk.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            build_sequence(r >= 85);
         end
         if ($urandom_range(0, 15) == 0) pace_on = !pace_on;
         foreach (chunk[i]) send_byte(chunk[i]);
         if (sent_count >= next_config) begin
            write_csr(asgr_pkg::CSR_DEFAULT_FG, pick_colour());
            write_csr(asgr_pkg::CSR_DEFAULT_BG, pick_colour());
            next_config += CONFIG_EVERY;
         end
      end
      pace_on = 1'b1;
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_valid = 1'b0;
      csr_index = asgr_pkg::CSR_DEFAULT_FG;
      csr_wdata = 24'h000000;
      reset = 1'b1;
      pace_on = 1'b1;
      mismatches = 0;
      results_seen = 0;
      sent_count = 0;
      idle_cycles = 0;
      dflt_fg = asgr_pkg::DEFAULT_FG_RESET;
      dflt_bg = asgr_pkg::DEFAULT_BG_RESET;
      fg_now = asgr_pkg::DEFAULT_FG_RESET;
      bg_now = asgr_pkg::DEFAULT_BG_RESET;
      tgt_bg = 1'b0;
      chan_r = 8'd0;
      chan_g = 8'd0;
      chan_b = 8'd0;
      bold = 1'b0;
      close_sequence();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_palette_and_bold();
      test_truecolour();
      test_default_colours();
      test_random_stream();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
